// File: design/sfdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdq_pkg
// Shared constant CODE_W and the elaboration-time generator of the spherical
// Fibonacci direction table.
// ----------------------------------------------------------------------------
package sfdq_pkg;

  localparam int CODE_W = 8;

  function automatic longint atan_q30(input int k);
    longint t;
    case (k)
      0:       t = 64'sd843314857;
      1:       t = 64'sd497837829;
      2:       t = 64'sd263043837;
      3:       t = 64'sd133525159;
      4:       t = 64'sd67021687;
      5:       t = 64'sd33543516;
      6:       t = 64'sd16775851;
      7:       t = 64'sd8388437;
      8:       t = 64'sd4194283;
      9:       t = 64'sd2097149;
      10:      t = 64'sd1048576;
      default: t = 64'sd1 <<< (30 - k);
    endcase
    return t;
  endfunction

  // one component (axis 0 = x, 1 = y, 2 = z) of table entry idx
  function automatic logic signed [31:0] fib_entry(input int idx, input int n,
                                                   input int fb, input int axis);
    longint num, zq, x, y, a, t, dx, dy, ox, oy, res;
    longint unsigned mag, numer, quo, v, r, b, rad, ph, den;
    int quad, s;
    num = longint'(n) - 2 * longint'(idx) - 1;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    numer = (mag << 30) + (longint'(n) >> 1);
    den = longint'(n);
    quo = 0;
    // rounded z by long division
    for (int k = 38; k >= 0; k--) begin
      if (numer >= (den << k)) begin
        numer = numer - (den << k);
        quo = quo | (64'd1 << k);
      end
    end
    zq = (num < 0) ? -longint'(quo) : longint'(quo);
    v = (64'd1 << 60) - longint'(zq * zq);
    r = 0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    rad = r;
    ph = (longint'(idx) * 64'h9E377A00) & 64'hFFFF_FFFF;
    quad = int'(ph >> 30);
    a = longint'(((ph & 64'h3FFF_FFFF) * 64'd6746518852) >> 32);
    x = longint'((rad * 64'd652032874) >> 30);
    y = 0;
    for (int k = 0; k < 28; k++) begin
      t = atan_q30(k);
      dx = y >>> k;
      dy = x >>> k;
      if (a >= 0) begin
        x = x - dx; y = y + dy; a = a - t;
      end else begin
        x = x + dx; y = y - dy; a = a + t;
      end
    end
    case (quad)
      0:       begin ox = x;  oy = y;  end
      1:       begin ox = -y; oy = x;  end
      2:       begin ox = -x; oy = -y; end
      default: begin ox = y;  oy = -x; end
    endcase
    case (axis)
      0:       res = ox;
      1:       res = oy;
      default: res = zq;
    endcase
    s = 30 - fb;
    res = (res + (64'sd1 <<< (s - 1))) >>> s;
    return res[31:0];
  endfunction

endpackage

// File: design/sfdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdq_cell
// One axis of the distance chain: adds the squared error of its component
// to the partial sum and passes the candidate on.
// ----------------------------------------------------------------------------
module sfdq_cell #(
  parameter int NUM_DIRECTIONS = 255,
  parameter int UNIT_FRAC_BITS = 15,
  parameter int AXIS = 0,
  parameter int IDX_W = 8,
  parameter int SUM_W = 34
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic signed [UNIT_FRAC_BITS+1:0] u_comp,
  input  logic                        in_valid,
  input  logic [IDX_W-1:0]            in_idx,
  input  logic [SUM_W-1:0]            in_sum,
  output logic                        out_valid,
  output logic [IDX_W-1:0]            out_idx,
  output logic [SUM_W-1:0]            out_sum
);
  import sfdq_pkg::*;

  localparam int F = UNIT_FRAC_BITS;

  logic signed [F+1:0] rom_c [NUM_DIRECTIONS];
  logic signed [F+2:0] err;
  logic signed [2*F+5:0] sq;
  logic valid_r;
  logic [IDX_W-1:0] idx_r;
  logic [SUM_W-1:0] sum_r;

  for (genvar g = 0; g < NUM_DIRECTIONS; g++) begin : g_rom
    localparam logic signed [31:0] EV = fib_entry(g, NUM_DIRECTIONS, F, AXIS);
    assign rom_c[g] = EV[F+1:0];
  end

  assign err = (F+3)'(rom_c[in_idx]) - (F+3)'(u_comp);
  assign sq  = err * err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    idx_r <= in_idx;
    sum_r <= in_sum + sq[SUM_W-1:0];
  end

  assign out_valid = valid_r;
  assign out_idx   = idx_r;
  assign out_sum   = sum_r;

endmodule

// File: design/spherical_fibonacci_direction_quantizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_fibonacci_direction_quantizer_top
// Normalizes origin minus endpoint and returns the index of the nearest
// spherical Fibonacci direction.
// ----------------------------------------------------------------------------
// order: shift-normalize, square the three components, bit-serial root,
//   three bit-serial divides, then the search chain over every direction;
//   a zero ray skips the arithmetic and goes straight to the search
// throughput: one item at a time, busy stays high until the result strobe
// the bit-serial root and divider and the one-candidate-per-cycle chain set the length of a run
// synchronous reset clears control; the direction table is constant logic
module spherical_fibonacci_direction_quantizer_top #(
  parameter int NUM_DIRECTIONS = 255,
  parameter int COORD_WIDTH = 32,
  parameter int UNIT_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_z,
  output logic                          out_valid,
  output logic [sfdq_pkg::CODE_W-1:0]   out_direction_code
);
  import sfdq_pkg::*;

  localparam int F     = UNIT_FRAC_BITS;
  localparam int CW    = COORD_WIDTH;
  localparam int MW    = (CW + 1 > 31) ? CW + 1 : 31;
  localparam int DW    = F + 34;
  localparam int IDX_W = $clog2(NUM_DIRECTIONS);
  localparam int SUM_W = 2 * F + 4;
  localparam int KC_W  = $clog2(F + 1) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIRECTIONS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DSET = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_SRCH = 3'd6;

  logic [2:0] state_r;
  logic busy_r;
  logic [2:0] sgn_r;
  logic [MW-1:0] m_r [3];
  logic [1:0] cnt_r;
  logic [63:0] acc_r, v_r, r_r, bit_r;
  logic [32:0] norm_r;
  logic [DW-1:0] rem_r, dv_r;
  logic [F:0] q_r;
  logic [KC_W-1:0] kc_r;
  logic signed [F+1:0] u_r [3];
  logic [IDX_W-1:0] feed_idx_r;
  logic feed_on_r;
  logic [SUM_W-1:0] best_r;
  logic [IDX_W-1:0] best_idx_r;
  logic out_valid_r;
  logic [CODE_W-1:0] out_code_r;

  logic signed [CW:0] d_in [3];
  logic [MW-1:0] big;
  logic [63:0] big64, sq_m, root_sum;
  logic root_ge;
  logic [63:0] r_step;
  logic div_ge;
  logic [F:0] q_step;
  logic ch_valid [4];
  logic [IDX_W-1:0] ch_idx [4];
  logic [SUM_W-1:0] ch_sum [4];
  logic take;

  assign d_in[0] = (CW+1)'(in_origin_x) - (CW+1)'(in_end_x);
  assign d_in[1] = (CW+1)'(in_origin_y) - (CW+1)'(in_end_y);
  assign d_in[2] = (CW+1)'(in_origin_z) - (CW+1)'(in_end_z);

  always_comb begin
    big = m_r[0];
    if (m_r[1] > big) big = m_r[1];
    if (m_r[2] > big) big = m_r[2];
  end
  assign big64 = 64'(big);

  assign sq_m     = 64'(m_r[cnt_r][30:0]) * 64'(m_r[cnt_r][30:0]);
  assign root_sum = r_r + bit_r;
  assign root_ge  = v_r >= root_sum;
  assign r_step   = root_ge ? ((r_r >> 1) + bit_r) : (r_r >> 1);
  assign div_ge   = rem_r >= dv_r;
  assign q_step   = {q_r[F-1:0], div_ge};

  // a candidate leaving the chain replaces the best one if it is index 0 or on a strict win
  assign take = ch_valid[3] && (ch_idx[3] == '0 || ch_sum[3] < best_r);

  assign ch_valid[0] = feed_on_r;
  assign ch_idx[0]   = feed_idx_r;
  assign ch_sum[0]   = '0;

  for (genvar c = 0; c < 3; c++) begin : g_cell
    sfdq_cell #(
      .NUM_DIRECTIONS(NUM_DIRECTIONS),
      .UNIT_FRAC_BITS(UNIT_FRAC_BITS),
      .AXIS(c),
      .IDX_W(IDX_W),
      .SUM_W(SUM_W)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .u_comp(u_r[c]),
      .in_valid(ch_valid[c]),
      .in_idx(ch_idx[c]),
      .in_sum(ch_sum[c]),
      .out_valid(ch_valid[c+1]),
      .out_idx(ch_idx[c+1]),
      .out_sum(ch_sum[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      feed_on_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            busy_r  <= 1'b1;
            state_r <= S_NORM;
            for (int j = 0; j < 3; j++) begin
              sgn_r[j] <= d_in[j][CW];
              m_r[j]   <= MW'(d_in[j][CW] ? -d_in[j] : d_in[j]);
            end
          end
        end
        S_NORM: begin
          if (big64 == 64'd0) begin
            for (int j = 0; j < 3; j++) u_r[j] <= '0;
            state_r    <= S_SRCH;
            feed_on_r  <= 1'b1;
            feed_idx_r <= '0;
          end else if (big64 >= 64'h8000_0000) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] >> 1;
          end else if (big64 < 64'h4000_0000) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] << 1;
          end else begin
            state_r <= S_SQ;
            cnt_r   <= 2'd0;
            acc_r   <= '0;
          end
        end
        S_SQ: begin
          if (cnt_r == 2'd2) begin
            v_r     <= acc_r + sq_m;
            r_r     <= '0;
            bit_r   <= 64'd1 << 62;
            state_r <= S_ROOT;
          end else begin
            acc_r <= acc_r + sq_m;
            cnt_r <= cnt_r + 2'd1;
          end
        end
        S_ROOT: begin
          if (root_ge) v_r <= v_r - root_sum;
          r_r   <= r_step;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            norm_r  <= r_step[32:0];
            cnt_r   <= 2'd0;
            state_r <= S_DSET;
          end
        end
        S_DSET: begin
          rem_r   <= (DW'(m_r[cnt_r][30:0]) << F) + DW'(norm_r >> 1);
          dv_r    <= DW'(norm_r) << F;
          q_r     <= '0;
          kc_r    <= KC_W'(F);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_ge) rem_r <= rem_r - dv_r;
          dv_r <= dv_r >> 1;
          q_r  <= q_step;
          if (kc_r == '0) begin
            u_r[cnt_r] <= sgn_r[cnt_r] ? -(F+2)'(q_step) : (F+2)'(q_step);
            if (cnt_r == 2'd2) begin
              state_r    <= S_SRCH;
              feed_on_r  <= 1'b1;
              feed_idx_r <= '0;
            end else begin
              cnt_r   <= cnt_r + 2'd1;
              state_r <= S_DSET;
            end
          end else begin
            kc_r <= kc_r - KC_W'(1);
          end
        end
        S_SRCH: begin
          if (feed_on_r) begin
            if (feed_idx_r == LAST_IDX) feed_on_r <= 1'b0;
            else feed_idx_r <= feed_idx_r + IDX_W'(1);
          end
          if (take) begin
            best_r     <= ch_sum[3];
            best_idx_r <= ch_idx[3];
          end
          if (ch_valid[3] && ch_idx[3] == LAST_IDX) begin
            out_valid_r <= 1'b1;
            out_code_r  <= CODE_W'(take ? ch_idx[3] : best_idx_r);
            busy_r      <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy               = busy_r;
  assign out_valid          = out_valid_r;
  assign out_direction_code = out_code_r;

  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE))
    else $error("busy flag out of step with state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r)
    else $error("item accepted but block not busy");

  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r) && !busy_r)
    else $error("result strobe without a finished item");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_code_r < CODE_W'(NUM_DIRECTIONS))
    else $error("direction code out of range");

endmodule
